/* rtl/ubsp_pkg.sv */
// Shared constants and types for the UART-to-stereo-PCM serializer.
package ubsp_pkg;

    localparam int unsigned CfgIndexWidth = 8;
    localparam int unsigned CfgDataWidth  = 8;

    // Configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_PAIRS_PER_BIT  = 8'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_PREAMBLE_BITS  = 8'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_STOP_BIT_COUNT = 8'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_ODD_PARITY     = 8'd3;

    // Register reset values
    localparam logic [7:0] PAIRS_PER_BIT_RST  = 8'd10;
    localparam logic [4:0] PREAMBLE_BITS_RST  = 5'd12;
    localparam logic [3:0] STOP_BIT_COUNT_RST = 4'd4;
    localparam logic       ODD_PARITY_RST     = 1'b0;

    // Line level to PCM
    localparam logic signed [15:0] LEVEL_HIGH_SAMPLE = 16'sh7FFF;
    localparam logic signed [15:0] LEVEL_LOW_SAMPLE  = 16'sh8000;

    // Bit position of the last data bit, counted down from here
    localparam logic [4:0] DATA_LAST_POS = 5'd7;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PRE    = 6'b000010,
        ST_START  = 6'b000100,
        ST_DATA   = 6'b001000,
        ST_PARITY = 6'b010000,
        ST_STOP   = 6'b100000
    } ubsp_state_t;

endpackage

/* rtl/uart_bits_to_stereo_pcm_unit.sv */
// Serializes bytes into UART-style frames, one stereo PCM line bit per beat.
//
//  channel | direction | beat content
//  s_      | in        | s_data_byte, s_message_start
//  m_      | out       | m_left_sample, m_right_sample, m_line_level, m_hold_pairs, m_frame_end
//  cfg_    | in        | cfg_wen, cfg_index, cfg_wdata (write only)
//
// One line bit leaves per cycle while m_ready does not stall the output, from a shift register and a bit counter.
// A frame holds a start bit, eight data bits, a parity bit and stop_bit_count stop bits
// (a stop count of 0 counts as 1), plus preamble_bits high bits first when message_start is set.
// The next byte is taken in the cycle that emits the last stop bit, so bytes run back to back.
// A stalled m_ready holds the sequencer in place; nothing is lost.
// Reset (aresetn low, synchronous) clears the sequencer, output valid and registers to defaults.
module uart_bits_to_stereo_pcm_unit
    import ubsp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_wen,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [7:0]               s_data_byte,
    input  logic                     s_message_start,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [15:0]       m_left_sample,
    output logic signed [15:0]       m_right_sample,
    output logic                     m_line_level,
    output logic [7:0]               m_hold_pairs,
    output logic                     m_frame_end
);

    logic [7:0]  pairs_per_bit_reg;
    logic [4:0]  preamble_bits_reg;
    logic [3:0]  stop_bit_count_reg;
    logic        odd_parity_reg;

    ubsp_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic        parity_reg, parity_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_level_reg, out_level_next;
    logic        out_last_reg, out_last_next;

    logic        advance;
    logic        last_stop;
    logic        accept;
    logic [3:0]  stops_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pairs_per_bit_reg  <= PAIRS_PER_BIT_RST;
            preamble_bits_reg  <= PREAMBLE_BITS_RST;
            stop_bit_count_reg <= STOP_BIT_COUNT_RST;
            odd_parity_reg     <= ODD_PARITY_RST;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_PAIRS_PER_BIT:  pairs_per_bit_reg  <= cfg_wdata;
                CFG_PREAMBLE_BITS:  preamble_bits_reg  <= cfg_wdata[4:0];
                CFG_STOP_BIT_COUNT: stop_bit_count_reg <= cfg_wdata[3:0];
                CFG_ODD_PARITY:     odd_parity_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign stops_eff = (stop_bit_count_reg == 4'd0) ? 4'd1 : stop_bit_count_reg;
    assign advance   = !out_valid_reg || m_ready;
    assign last_stop = (state_reg == ST_STOP) && (cnt_reg == 5'd1);
    assign s_ready   = (state_reg == ST_IDLE) || (last_stop && advance);
    assign accept    = s_valid && s_ready;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        shift_next     = shift_reg;
        parity_next    = parity_reg;
        out_valid_next = out_valid_reg;
        out_level_next = out_level_reg;
        out_last_next  = out_last_reg;

        if (advance) begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    out_valid_next = 1'b0;
                end
                ST_PRE: begin
                    out_level_next = 1'b1;
                    cnt_next       = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1) begin
                        state_next = ST_START;
                    end
                end
                ST_START: begin
                    out_level_next = 1'b0;
                    cnt_next       = DATA_LAST_POS;
                    state_next     = ST_DATA;
                end
                ST_DATA: begin
                    // LSB first: shift right, fold each bit into parity
                    out_level_next = shift_reg[0];
                    parity_next    = parity_reg ^ shift_reg[0];
                    shift_next     = {1'b0, shift_reg[7:1]};
                    cnt_next       = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        state_next = ST_PARITY;
                    end
                end
                ST_PARITY: begin
                    out_level_next = parity_reg ^ odd_parity_reg;
                    cnt_next       = {1'b0, stops_eff};
                    state_next     = ST_STOP;
                end
                ST_STOP: begin
                    out_level_next = 1'b1;
                    out_last_next  = (cnt_reg == 5'd1);
                    cnt_next       = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1) begin
                        state_next = ST_IDLE;
                    end
                end
                default: begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            endcase
        end

        // A new byte overrides the sequencer; output register update above stands
        if (accept) begin
            shift_next  = s_data_byte;
            parity_next = 1'b0;
            cnt_next    = preamble_bits_reg;
            if (s_message_start && (preamble_bits_reg != 5'd0)) begin
                state_next = ST_PRE;
            end else begin
                state_next = ST_START;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        shift_reg     <= shift_next;
        parity_reg    <= parity_next;
        out_level_reg <= out_level_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_line_level   = out_level_reg;
    assign m_frame_end    = out_last_reg;
    assign m_left_sample  = out_level_reg ? LEVEL_HIGH_SAMPLE : LEVEL_LOW_SAMPLE;
    assign m_right_sample = out_level_reg ? LEVEL_LOW_SAMPLE : LEVEL_HIGH_SAMPLE;
    assign m_hold_pairs   = (pairs_per_bit_reg == 8'd0) ? 8'd1 : pairs_per_bit_reg;

    // A frame always closes on a high line bit
    a_frame_end_high: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_end) |-> m_line_level)
        else $error("frame_end on a low line bit");

    // An accepted byte puts the sequencer to work in the next cycle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("sequencer idle after accepting a byte");

    // Emitting the last stop bit yields a frame_end beat
    a_last_stop_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_stop && advance) |=> (m_valid && m_frame_end))
        else $error("last stop bit without frame_end");

    // Sequencer state stays one-hot
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule
